[hdl/plate_pixel_color_edge_filter_macros.svh]
// Assertion macros for the plate pixel color/edge filter.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef PLATE_PIXEL_COLOR_EDGE_FILTER_MACROS_SVH
`define PLATE_PIXEL_COLOR_EDGE_FILTER_MACROS_SVH

`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define PPCEF_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("ppcef check failed");
// Condition in one cycle implies a result in the next.
`define PPCEF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ppcef check failed");
`else
`define PPCEF_ASSERT(label, clk, rst_n, prop)
`define PPCEF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[hdl/ppcef_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and the gray helper for the plate pixel filter.
// No dependencies.
package ppcef_pkg;

    localparam logic [7:0] MARK_ON  = 8'd255;
    localparam logic [7:0] MARK_OFF = 8'd0;

    localparam logic       RST_RGB_MODE        = 1'b1;
    localparam logic [7:0] RST_BRIGHT_MIN      = 8'd140;
    localparam logic [7:0] RST_SAT_MAX         = 8'd20;
    localparam logic [7:0] RST_EDGE_MIN        = 8'd15;
    localparam logic [7:0] RST_BLUE_MIN        = 8'd90;
    localparam logic [7:0] RST_BLUE_OVER_RED   = 8'd15;
    localparam logic [7:0] RST_BLUE_OVER_GREEN = 8'd10;

    typedef enum logic [2:0] {
        REG_RGB_MODE        = 3'd0,
        REG_BRIGHT_MIN      = 3'd1,
        REG_SAT_MAX         = 3'd2,
        REG_EDGE_MIN        = 3'd3,
        REG_BLUE_MIN        = 3'd4,
        REG_BLUE_OVER_RED   = 3'd5,
        REG_BLUE_OVER_GREEN = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       row_end;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] mask_value;
        logic       row_last;
        logic       run_last;
    } t_res_out;

    // Thresholds used by the classifier.
    typedef struct packed {
        logic [7:0] bright_min;
        logic [7:0] sat_max;
        logic [7:0] edge_min;
        logic [7:0] blue_min;
        logic [7:0] blue_over_red;
        logic [7:0] blue_over_green;
    } t_thresh;

    function automatic logic [7:0] absdiff8(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    // (r+g+b)/3 as a multiply by 683/2048; exact for sums up to 765.
    function automatic logic [7:0] gray_of(input logic [7:0] r, input logic [7:0] g,
                                           input logic [7:0] b);
        logic [9:0]  sum;
        logic [20:0] prod;
        sum  = {2'b00, r} + {2'b00, g} + {2'b00, b};
        prod = {11'd0, sum} * 21'd683;
        return prod[18:11];
    endfunction

endpackage

[hdl/ppcef_classify.sv]
`timescale 1ns / 1ps
// Pixel classifier: bright, low-saturation, strong-edge test or blue test.
// Depends on ppcef_pkg.
module ppcef_classify
    import ppcef_pkg::*;
(
    input  logic [7:0] i_red,
    input  logic [7:0] i_green,
    input  logic [7:0] i_blue,
    input  logic [7:0] i_edge,
    input  t_thresh    i_thr,
    output logic       o_mark
);

    logic w_bright;
    logic w_low_sat;
    logic w_strong;
    logic w_blue;

    always_comb begin
        w_bright  = (i_red > i_thr.bright_min) && (i_green > i_thr.bright_min) &&
                    (i_blue > i_thr.bright_min);
        w_low_sat = (absdiff8(i_red, i_green) < i_thr.sat_max) &&
                    (absdiff8(i_red, i_blue) < i_thr.sat_max) &&
                    (absdiff8(i_green, i_blue) < i_thr.sat_max);
        w_strong  = i_edge > i_thr.edge_min;
        // margins add in 9 bits so red + margin cannot wrap
        w_blue    = (i_blue > i_thr.blue_min) &&
                    ({1'b0, i_blue} > ({1'b0, i_red} + {1'b0, i_thr.blue_over_red})) &&
                    ({1'b0, i_blue} > ({1'b0, i_green} + {1'b0, i_thr.blue_over_green}));
        o_mark    = (w_bright && w_low_sat && w_strong) || w_blue;
    end

endmodule

[hdl/plate_pixel_color_edge_filter.sv]
`timescale 1ns / 1ps
// Plate pixel color/edge filter top level: APB registers, pixel stage, result FIFO.
// Depends on ppcef_pkg, ppcef_classify and the assertion macro header.
//
// Input channel: i_valid / o_stall carry one pixel (i_pix) per transaction in
// raster order; row_end marks the last pixel of a row. Output channel:
// o_valid / i_stall carry one result (o_res) per transaction.
// Each pixel is registered, classified in the next cycle and pushed into a
// FIFO_DEPTH-entry result FIFO. In RGB mode a pixel is marked once the next
// pixel of its row arrives, so a pixel with row_end produces two results and
// one without produces one, each one fewer when no pixel is held (first pixel
// of a row).
// A pixel's results pass the r_in stage register, then the FIFO, before o_valid.
// Throughput: one pixel per cycle unless o_stall; a row gives as many results as
// pixels, drained one per cycle unless i_stall; FIFO absorbs the row-end pair.
// o_stall is raised when the FIFO might not hold the results of the pixel in
// the stage register plus one more pixel; it depends on registers only.
// A stalled receiver leaves o_res and o_valid unchanged until taken.
// Reset (synchronous, active low) empties the pipeline and FIFO, drops any
// held pixel and loads the default thresholds with RGB mode on.
// Registers are on the APB port at byte address 4*index, always ready.
`include "plate_pixel_color_edge_filter_macros.svh"
module plate_pixel_color_edge_filter
    import ppcef_pkg::*;
#(
    parameter int FIFO_DEPTH = 8   // power of two, at least 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_pix_in     i_pix,
    output logic        o_valid,
    input  logic        i_stall,
    output t_res_out    o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int PW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam logic [CW:0] STALL_ABOVE = (CW + 1)'(FIFO_DEPTH - 2);
    localparam logic [CW:0] PEND_TWO    = (CW + 1)'(2);

    // configuration
    logic     r_rgb_mode;
    t_thresh  r_thr;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[4:2]);
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rgb_mode            <= RST_RGB_MODE;
            r_thr.bright_min      <= RST_BRIGHT_MIN;
            r_thr.sat_max         <= RST_SAT_MAX;
            r_thr.edge_min        <= RST_EDGE_MIN;
            r_thr.blue_min        <= RST_BLUE_MIN;
            r_thr.blue_over_red   <= RST_BLUE_OVER_RED;
            r_thr.blue_over_green <= RST_BLUE_OVER_GREEN;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_RGB_MODE:        r_rgb_mode            <= pwdata[0];
                REG_BRIGHT_MIN:      r_thr.bright_min      <= pwdata[7:0];
                REG_SAT_MAX:         r_thr.sat_max         <= pwdata[7:0];
                REG_EDGE_MIN:        r_thr.edge_min        <= pwdata[7:0];
                REG_BLUE_MIN:        r_thr.blue_min        <= pwdata[7:0];
                REG_BLUE_OVER_RED:   r_thr.blue_over_red   <= pwdata[7:0];
                REG_BLUE_OVER_GREEN: r_thr.blue_over_green <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_RGB_MODE:        prdata = {31'd0, r_rgb_mode};
            REG_BRIGHT_MIN:      prdata = {24'd0, r_thr.bright_min};
            REG_SAT_MAX:         prdata = {24'd0, r_thr.sat_max};
            REG_EDGE_MIN:        prdata = {24'd0, r_thr.edge_min};
            REG_BLUE_MIN:        prdata = {24'd0, r_thr.blue_min};
            REG_BLUE_OVER_RED:   prdata = {24'd0, r_thr.blue_over_red};
            REG_BLUE_OVER_GREEN: prdata = {24'd0, r_thr.blue_over_green};
            default:             prdata = 32'd0;
        endcase
    end

    // input stage and held pixel
    logic          r_in_vld;
    t_pix_in       r_in;
    logic          r_held_vld;
    logic [7:0]    r_held_red;
    logic [7:0]    r_held_green;
    logic [7:0]    r_held_blue;
    logic [7:0]    r_held_gray;

    // result FIFO
    t_res_out      r_fifo [FIFO_DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;

    logic          w_in_acc;
    logic          w_pop;
    logic [CW:0]   w_occ;
    logic [7:0]    w_gray_cur;
    logic [7:0]    w_edge;
    logic          w_mark_held;
    logic          w_mark_cur;
    logic          w_e0;
    logic          w_e1;
    t_res_out      w_res0;
    t_res_out      w_res1;
    t_res_out      w_slot_a;
    logic [1:0]    n_push;
    logic [PW-1:0] w_wr_nxt;

    assign w_occ    = {1'b0, r_cnt} + (r_in_vld ? PEND_TWO : '0);
    assign o_stall  = w_occ > STALL_ABOVE;
    assign w_in_acc = i_valid && !o_stall;
    assign o_valid  = r_cnt != '0;
    assign o_res    = r_fifo[r_rd];
    assign w_pop    = o_valid && !i_stall;
    assign w_wr_nxt = r_wr + PW'(1);

    assign w_gray_cur = gray_of(r_in.red, r_in.green, r_in.blue);
    // passthrough mode flushes the held pixel with no edge
    assign w_edge     = r_rgb_mode ? absdiff8(w_gray_cur, r_held_gray) : 8'd0;

    ppcef_classify u_cls_held (
        .i_red   (r_held_red),
        .i_green (r_held_green),
        .i_blue  (r_held_blue),
        .i_edge  (w_edge),
        .i_thr   (r_thr),
        .o_mark  (w_mark_held)
    );

    ppcef_classify u_cls_cur (
        .i_red   (r_in.red),
        .i_green (r_in.green),
        .i_blue  (r_in.blue),
        .i_edge  (8'd0),
        .i_thr   (r_thr),
        .o_mark  (w_mark_cur)
    );

    always_comb begin
        w_e0 = r_in_vld && r_held_vld;
        w_e1 = r_in_vld && (!r_rgb_mode || r_in.row_end);
        w_res0.mask_value = w_mark_held ? MARK_ON : MARK_OFF;
        w_res0.row_last   = 1'b0;
        w_res0.run_last   = !w_e1;
        if (r_rgb_mode) begin
            w_res1.mask_value = w_mark_cur ? MARK_ON : MARK_OFF;
            w_res1.row_last   = 1'b1;
        end else begin
            w_res1.mask_value = r_in.red;
            w_res1.row_last   = r_in.row_end;
        end
        w_res1.run_last = 1'b1;
        w_slot_a = w_e0 ? w_res0 : w_res1;
        n_push   = {1'b0, w_e0} + {1'b0, w_e1};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld   <= 1'b0;
            r_held_vld <= 1'b0;
            r_wr       <= '0;
            r_rd       <= '0;
            r_cnt      <= '0;
        end else begin
            r_in_vld <= w_in_acc;
            if (r_in_vld) begin
                r_held_vld <= r_rgb_mode && !r_in.row_end;
            end
            r_wr  <= r_wr + PW'(n_push);
            r_rd  <= r_rd + PW'(w_pop);
            r_cnt <= r_cnt + CW'(n_push) - CW'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in <= i_pix;
        end
        if (r_in_vld && r_rgb_mode && !r_in.row_end) begin
            r_held_red   <= r_in.red;
            r_held_green <= r_in.green;
            r_held_blue  <= r_in.blue;
            r_held_gray  <= w_gray_cur;
        end
        if (n_push != 2'd0) begin
            r_fifo[r_wr] <= w_slot_a;
        end
        if (n_push == 2'd2) begin
            r_fifo[w_wr_nxt] <= w_res1;
        end
    end

    `PPCEF_ASSERT(a_cnt_bound, i_clk, i_rst_n, r_cnt <= CW'(FIFO_DEPTH))
    `PPCEF_ASSERT(a_room_for_stage, i_clk, i_rst_n, !r_in_vld || (r_cnt <= CW'(FIFO_DEPTH - 2)))
    `PPCEF_ASSERT_NEXT(a_pass_no_hold, i_clk, i_rst_n, r_in_vld && !r_rgb_mode, !r_held_vld)
    `PPCEF_ASSERT_NEXT(a_row_end_no_hold, i_clk, i_rst_n, r_in_vld && r_in.row_end, !r_held_vld)

endmodule
